@@ rtl/core/arpr_pkg.sv @@
// Shared types and constants for the ARP request responder.
// Holds payload structs, the reply descriptor, register map and frame layout.
// No dependencies.
package arpr_pkg;

  localparam int MAX_FRAME_BYTES = 2048;
  localparam int CLIENT_COUNT    = 2;
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int MIN_FRAME       = 42;
  localparam int REPLY_LEN       = 56;
  localparam int K_W             = $clog2(REPLY_LEN);
  localparam int HDR_BITS        = 8 * MIN_FRAME;

  localparam logic [15:0] ETH_TYPE_ARP   = 16'h0806;
  localparam logic [15:0] ETH_TYPE_IPV4  = 16'h0800;
  localparam logic [15:0] ARP_HTYPE_ETH  = 16'h0001;
  localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;
  localparam logic [15:0] ARP_OP_REPLY   = 16'h0002;
  localparam logic [7:0]  ARP_HLEN       = 8'd6;
  localparam logic [7:0]  ARP_PLEN       = 8'd4;

  localparam logic [47:0] MAC0_RESET = 48'h5254_0100_0000;
  localparam logic [47:0] MAC1_RESET = 48'h5254_0100_0001;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  typedef enum logic [1:0] {
    REG_CLIENT0_IP  = 2'd0,
    REG_CLIENT1_IP  = 2'd1,
    REG_CLIENT0_MAC = 2'd2,
    REG_CLIENT1_MAC = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_last;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       client_index;
  } tx_item_t;

  typedef struct packed {
    logic [31:0] client0_ip;
    logic [31:0] client1_ip;
    logic [47:0] client0_mac;
    logic [47:0] client1_mac;
  } cfg_t;

  typedef struct packed {
    logic [47:0] requester_mac;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic        client_index;
  } reply_desc_t;

endpackage

@@ rtl/core/arpr_cfg_regs.sv @@
// APB configuration registers: client IP and MAC addresses.
// Depends on arpr_pkg.
module arpr_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [arpr_pkg::ADDR_W-1:0]   paddr,
  input  logic [arpr_pkg::DATA_W-1:0]   pwdata,
  output logic [arpr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output arpr_pkg::cfg_t                cfg
);
  import arpr_pkg::*;

  reg_index_t idx;
  logic       wr_en;

  assign idx    = reg_index_t'(paddr[4:3]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.client0_ip  <= '0;
      cfg.client1_ip  <= '0;
      cfg.client0_mac <= MAC0_RESET;
      cfg.client1_mac <= MAC1_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_CLIENT0_IP:  cfg.client0_ip  <= pwdata[31:0];
        REG_CLIENT1_IP:  cfg.client1_ip  <= pwdata[31:0];
        REG_CLIENT0_MAC: cfg.client0_mac <= pwdata[47:0];
        REG_CLIENT1_MAC: cfg.client1_mac <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CLIENT0_IP:  prdata = {32'd0, cfg.client0_ip};
      REG_CLIENT1_IP:  prdata = {32'd0, cfg.client1_ip};
      REG_CLIENT0_MAC: prdata = {16'd0, cfg.client0_mac};
      REG_CLIENT1_MAC: prdata = {16'd0, cfg.client1_mac};
      default:         prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/arpr_rx_parser.sv @@
// Front end: captures ARP fields from the received byte stream and decides
// on the final byte whether a reply descriptor is queued. Depends on arpr_pkg.
module arpr_rx_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  arpr_pkg::rx_item_t    rx_item,
  input  arpr_pkg::cfg_t        cfg,
  output logic                  desc_push,
  output arpr_pkg::reply_desc_t desc
);
  import arpr_pkg::*;

  logic [POS_W-1:0] pos;
  logic [15:0]      ether_kind, ether_kind_next;
  logic [15:0]      arp_op, arp_op_next;
  logic [47:0]      req_mac, req_mac_next;
  logic [47:0]      sha, sha_next;
  logic [31:0]      spa, spa_next;
  logic [31:0]      tpa, tpa_next;
  logic [7:0]       b;
  logic             is_request, match0, match1;

  assign b = rx_item.rx_byte;

  always_comb begin
    req_mac_next    = req_mac;
    ether_kind_next = ether_kind;
    arp_op_next     = arp_op;
    sha_next        = sha;
    spa_next        = spa;
    tpa_next        = tpa;
    if (pos >= POS_W'(6) && pos <= POS_W'(11)) req_mac_next = {req_mac[39:0], b};
    else if (pos == POS_W'(12) || pos == POS_W'(13)) ether_kind_next = {ether_kind[7:0], b};
    else if (pos == POS_W'(20) || pos == POS_W'(21)) arp_op_next = {arp_op[7:0], b};
    else if (pos >= POS_W'(22) && pos <= POS_W'(27)) sha_next = {sha[39:0], b};
    else if (pos >= POS_W'(28) && pos <= POS_W'(31)) spa_next = {spa[23:0], b};
    else if (pos >= POS_W'(38) && pos <= POS_W'(41)) tpa_next = {tpa[23:0], b};
  end

  // the final byte itself may complete the target IP, so decide on _next values
  assign is_request = (pos >= POS_W'(MIN_FRAME - 1)) && (ether_kind_next == ETH_TYPE_ARP)
                      && (arp_op_next == ARP_OP_REQUEST);
  assign match0     = (cfg.client0_ip == tpa_next);
  assign match1     = (CLIENT_COUNT >= 2) && (cfg.client1_ip == tpa_next);
  assign desc_push  = accept && rx_item.rx_last && is_request && (match0 || match1);

  assign desc.requester_mac = req_mac_next;
  assign desc.sender_mac    = sha_next;
  assign desc.sender_ip     = spa_next;
  assign desc.target_ip     = tpa_next;
  assign desc.client_index  = !match0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      ether_kind <= '0;
      arp_op     <= '0;
      req_mac    <= '0;
      sha        <= '0;
      spa        <= '0;
      tpa        <= '0;
    end else if (accept) begin
      ether_kind <= ether_kind_next;
      arp_op     <= arp_op_next;
      req_mac    <= req_mac_next;
      sha        <= sha_next;
      spa        <= spa_next;
      tpa        <= tpa_next;
      if (rx_item.rx_last) begin
        pos <= '0;
      end else if (pos < POS_W'(MAX_FRAME_BYTES)) begin
        pos <= pos + 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/arpr_desc_fifo.sv @@
// Two-entry queue of reply descriptors between the parser and the builder.
// Depends on arpr_pkg.
module arpr_desc_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  arpr_pkg::reply_desc_t wr_data,
  input  logic                  rd_en,
  output arpr_pkg::reply_desc_t rd_data,
  output logic                  valid,
  output logic                  full
);
  import arpr_pkg::*;

  reply_desc_t mem [2];
  logic        wptr, rptr;
  logic [1:0]  count;

  assign valid   = (count != 2'd0);
  assign full    = (count == 2'd2);
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (wr_en) wptr <= !wptr;
      if (rd_en) rptr <= !rptr;
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/arpr_tx_builder.sv @@
// Back end: streams the 56-byte ARP reply for the head descriptor into an
// output register, folding the header checksum as bytes go out. Depends on arpr_pkg.
module arpr_tx_builder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  desc_valid,
  input  arpr_pkg::reply_desc_t desc,
  input  arpr_pkg::cfg_t        cfg,
  output logic                  desc_pop,
  input  logic                  pop,
  output logic                  empty,
  output arpr_pkg::tx_item_t    tx_item
);
  import arpr_pkg::*;

  logic [K_W-1:0]      k;
  logic                out_valid;
  logic [15:0]         csum, csum_next;
  logic [16:0]         csum_add;
  logic [47:0]         mac;
  logic [HDR_BITS-1:0] hdr;
  logic [5:0]          hdr_sel;
  logic [7:0]          byte_val, hdr_byte;
  logic                advance, is_last;

  assign mac = desc.client_index ? cfg.client1_mac : cfg.client0_mac;
  assign hdr = {desc.requester_mac, mac, ETH_TYPE_ARP, ARP_HTYPE_ETH, ETH_TYPE_IPV4,
                ARP_HLEN, ARP_PLEN, ARP_OP_REPLY, mac, desc.target_ip,
                desc.sender_mac, desc.sender_ip};
  assign hdr_sel  = 6'(MIN_FRAME - 1) - 6'(k);
  assign hdr_byte = hdr[{hdr_sel, 3'b000} +: 8];

  always_comb begin
    if (k < K_W'(MIN_FRAME)) begin
      byte_val = hdr_byte;
    end else if (k == K_W'(52)) begin
      byte_val = ~csum[15:8];
    end else if (k == K_W'(53)) begin
      byte_val = ~csum[7:0];
    end else begin
      byte_val = 8'd0;
    end
  end

  // running ones' complement sum with end-around carry; even bytes are high
  always_comb begin
    csum_add  = {1'b0, (k == '0) ? 16'd0 : csum}
                + (k[0] ? {9'd0, hdr_byte} : {1'b0, hdr_byte, 8'd0});
    csum_next = csum_add[15:0] + {15'd0, csum_add[16]};
  end

  assign advance  = desc_valid && (!out_valid || pop);
  assign is_last  = (k == K_W'(REPLY_LEN - 1));
  assign desc_pop = advance && is_last;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
      k         <= is_last ? '0 : k + 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tx_item.tx_byte      <= byte_val;
      tx_item.tx_last      <= is_last;
      tx_item.client_index <= desc.client_index;
      if (k < K_W'(MIN_FRAME)) csum <= csum_next;
    end
  end

endmodule

@@ rtl/core/arp_request_responder.sv @@
// ARP request responder top level. The final accepted request byte queues a reply
// descriptor in the FIFO, from which the builder registers the 56 reply bytes. Input takes
// one byte per cycle while full is low; a reply leaves one byte per cycle while pop is held.
// Up to two replies queue in the descriptor FIFO; full is high while it holds two.
// Reset (synchronous) clears parser state and queues; client MACs reset to 52:54:01:00:00:0x.
module arp_request_responder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [arpr_pkg::ADDR_W-1:0] paddr,
  input  logic [arpr_pkg::DATA_W-1:0] pwdata,
  output logic [arpr_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        push,
  output logic                        full,
  input  arpr_pkg::rx_item_t          rx_item,
  output logic                        empty,
  input  logic                        pop,
  output arpr_pkg::tx_item_t          tx_item
);
  import arpr_pkg::*;

  cfg_t        cfg;
  reply_desc_t new_desc, head_desc;
  logic        accept, desc_push, desc_pop, desc_valid;

  assign accept = push && !full;

  arpr_cfg_regs u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  arpr_rx_parser u_parser (
    .clk, .rst, .accept, .rx_item, .cfg, .desc_push, .desc(new_desc)
  );

  arpr_desc_fifo u_fifo (
    .clk, .rst,
    .wr_en(desc_push), .wr_data(new_desc),
    .rd_en(desc_pop), .rd_data(head_desc),
    .valid(desc_valid), .full
  );

  arpr_tx_builder u_builder (
    .clk, .rst, .desc_valid, .desc(head_desc), .cfg, .desc_pop,
    .pop, .empty, .tx_item
  );

endmodule
